// ===== rtl/dtfp_pkg.sv =====
`default_nettype none

package dtfp_pkg;

    // Number of fraction digits that add weight; later digits are consumed only.
    localparam int unsigned FRAC_DIGITS = 9;

    // Width of the saturating byte counter and the fraction digit counter.
    localparam int unsigned COUNT_W  = 8;
    localparam int unsigned FCOUNT_W = 4;

    // Largest integer part, 2^31-1.
    localparam logic [30:0] INT_MAX = 31'h7FFF_FFFF;

    // Characters that the grammar recognises.
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Packed widths on the streaming ports.
    localparam int unsigned S_TDATA_W = 8;
    localparam int unsigned M_TDATA_W = 80;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2
    } phase_t;

    // What the parser reports for the byte at its input.
    typedef struct packed {
        logic               done;
        logic signed [63:0] value;
        logic [7:0]         consumed;
        logic               overflow;
    } dtfp_result_t;

    // Weight of the k-th fraction digit, round(2^32 / 10^(k+1)).
    function automatic logic [31:0] frac_weight(input logic [FCOUNT_W-1:0] idx);
        logic [31:0] w;
        case (idx)
            4'd0:    w = 32'd429496730;
            4'd1:    w = 32'd42949673;
            4'd2:    w = 32'd4294967;
            4'd3:    w = 32'd429497;
            4'd4:    w = 32'd42950;
            4'd5:    w = 32'd4295;
            4'd6:    w = 32'd429;
            4'd7:    w = 32'd43;
            4'd8:    w = 32'd4;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dtfp_parser.sv =====
`default_nettype none

module dtfp_parser (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  step_i,
    input  wire logic [7:0]            byte_i,
    output dtfp_pkg::dtfp_result_t     result_o
);
    import dtfp_pkg::*;

    phase_t                phase_reg, phase_next;
    logic                  negative_reg, negative_next;
    logic [30:0]           int_acc_reg, int_acc_next;
    logic [31:0]           frac_acc_reg, frac_acc_next;
    logic [FCOUNT_W-1:0]   fcount_reg, fcount_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic                  sat_reg, sat_next;

    logic                  is_digit;
    logic                  is_space;
    logic [3:0]            digit;
    logic [34:0]           int_sum;
    logic [35:0]           frac_prod;
    logic [31:0]           frac_sum;
    logic                  eval_int;
    logic                  take;
    logic                  done;
    logic [63:0]           magnitude;

    // Character classes of the current byte.
    assign is_digit = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
    assign is_space = (byte_i == CH_SPACE) || (byte_i == CH_TAB) ||
                      (byte_i == CH_LF) || (byte_i == CH_CR);
    assign digit    = is_digit ? 4'(byte_i - CH_ZERO) : 4'd0;

    // Integer step: acc*10 + d, built from two shifts and an add.
    assign int_sum  = {1'b0, int_acc_reg, 3'b000} + {3'b000, int_acc_reg, 1'b0}
                    + {31'd0, digit};

    // Fraction step: one narrow multiply by the table weight.
    assign frac_prod = {32'd0, digit} * {4'd0, frac_weight(fcount_reg)};
    assign frac_sum  = frac_acc_reg + frac_prod[31:0];

    // Next state for the byte at the input.
    always_comb begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        int_acc_next  = int_acc_reg;
        frac_acc_next = frac_acc_reg;
        fcount_next   = fcount_reg;
        count_next    = count_reg;
        sat_next      = sat_reg;
        eval_int      = 1'b0;
        take          = 1'b0;
        done          = 1'b0;

        unique case (phase_reg)
            PH_INT: begin
                eval_int = 1'b1;
            end
            PH_FRAC: begin
                if (is_digit) begin
                    take = 1'b1;
                    if (fcount_reg < FCOUNT_W'(FRAC_DIGITS)) begin
                        frac_acc_next = frac_sum;
                        fcount_next   = fcount_reg + FCOUNT_W'(1);
                    end
                end else begin
                    done = 1'b1;
                end
            end
            default: begin
                if (is_space) begin
                    take = 1'b1;
                end else if ((byte_i == CH_PLUS) || (byte_i == CH_MINUS)) begin
                    take          = 1'b1;
                    negative_next = (byte_i == CH_MINUS);
                    phase_next    = PH_INT;
                end else begin
                    eval_int = 1'b1;
                end
            end
        endcase

        // A byte that falls through from whitespace is judged as an integer byte.
        if (eval_int) begin
            if (is_digit) begin
                take       = 1'b1;
                phase_next = PH_INT;
                if (int_sum > {4'd0, INT_MAX}) begin
                    int_acc_next = INT_MAX;
                    sat_next     = 1'b1;
                end else begin
                    int_acc_next = int_sum[30:0];
                end
            end else if (byte_i == CH_POINT) begin
                take       = 1'b1;
                phase_next = PH_FRAC;
            end else begin
                done = 1'b1;
            end
        end

        // The byte counter stops at its top value.
        if (take && (count_reg != {COUNT_W{1'b1}})) begin
            count_next = count_reg + COUNT_W'(1);
        end

        // The ending byte returns the parser to its starting state.
        if (done) begin
            phase_next    = PH_SKIP;
            negative_next = 1'b0;
            int_acc_next  = '0;
            frac_acc_next = '0;
            fcount_next   = '0;
            count_next    = '0;
            sat_next      = 1'b0;
        end
    end

    // Result as it stands before the ending byte.
    assign magnitude         = {1'b0, int_acc_reg, frac_acc_reg};
    assign result_o.done     = done;
    assign result_o.value    = negative_reg ? (64'd0 - magnitude) : magnitude;
    assign result_o.consumed = count_reg;
    assign result_o.overflow = sat_reg;

    // Parser state advances only on step_i, when a byte is processed.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_SKIP;
            negative_reg <= 1'b0;
            int_acc_reg  <= '0;
            frac_acc_reg <= '0;
            fcount_reg   <= '0;
            count_reg    <= '0;
            sat_reg      <= 1'b0;
        end else if (step_i) begin
            phase_reg    <= phase_next;
            negative_reg <= negative_next;
            int_acc_reg  <= int_acc_next;
            frac_acc_reg <= frac_acc_next;
            fcount_reg   <= fcount_next;
            count_reg    <= count_next;
            sat_reg      <= sat_next;
        end
    end

    // The fraction counter never passes the number of weighted digits.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fcount_reg <= FCOUNT_W'(FRAC_DIGITS))
    else $error("fraction digit count beyond limit");

    // After an ending byte the parser starts afresh.
    assert property (@(posedge aclk) disable iff (!aresetn)
        step_i && done |=> (phase_reg == PH_SKIP) && (count_reg == '0) && !sat_reg)
    else $error("parser not cleared after a result");

    // Once saturated, the integer part sits at its maximum.
    assert property (@(posedge aclk) disable iff (!aresetn)
        sat_reg |-> (int_acc_reg == INT_MAX))
    else $error("saturation flag without saturated integer");

endmodule

`default_nettype wire

// ===== rtl/decimal_text_to_fixed_point_unit.sv =====
`default_nettype none

// Streaming decimal text parser. Each accepted s_tdata byte is one character;
// leading space, tab, LF and CR are skipped, then one optional sign, integer
// digits, an optional point and fraction digits are taken. The first byte
// that does not fit ends the number and yields one request on the m_ side:
// the value in Q31.32 two's complement, the bytes consumed (saturating at
// 255) and an integer overflow flag. The ending byte itself is not counted.
// The unit takes one byte per clock cycle when it does not stall: each byte
// passes an input register and the parsing logic (a shift-add by ten on the
// integer part and a small multiply by a fraction weight); the result of an
// ending byte is then held in a result register until it is taken.
// Input stalls only while a finished result waits in the result
// register and the next ending byte needs that slot.
module decimal_text_to_fixed_point_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output      logic                               s_tready,
    input  wire logic [dtfp_pkg::S_TDATA_W-1:0]     s_tdata,   // [7:0] text_byte
    output      logic                               m_tvalid,
    input  wire logic                               m_tready,
    output      logic [dtfp_pkg::M_TDATA_W-1:0]     m_tdata    // [63:0] value,
                                                               // [71:64] consumed,
                                                               // [72] overflow, rest 0
);
    import dtfp_pkg::*;

    logic               in_valid_reg, in_valid_next;
    logic [7:0]         in_byte_reg;
    logic               out_valid_reg, out_valid_next;
    logic signed [63:0] out_value_reg;
    logic [7:0]         out_consumed_reg;
    logic               out_overflow_reg;

    dtfp_result_t       result;
    logic               out_free;
    logic               fire;
    logic               s_take;

    // Parsing logic with its state.
    dtfp_parser u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step_i   (fire),
        .byte_i   (in_byte_reg),
        .result_o (result)
    );

    // A byte is processed unless it ends a number and the result slot is full.
    assign out_free = !out_valid_reg || m_tready;
    assign fire     = in_valid_reg && (!result.done || out_free);
    assign s_tready = !in_valid_reg || fire;
    assign s_take   = s_tvalid && s_tready;

    // Input register occupancy.
    always_comb begin
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    // Result register occupancy.
    always_comb begin
        if (fire && result.done) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_byte_reg <= s_tdata[7:0];
        end
        if (fire && result.done) begin
            out_value_reg    <= result.value;
            out_consumed_reg <= result.consumed;
            out_overflow_reg <= result.overflow;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - 73){1'b0}}, out_overflow_reg, out_consumed_reg,
                       out_value_reg};

    // A result appears only after an ending byte was parsed.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(fire && result.done))
    else $error("result without an ending byte");

    // A waiting byte that is not processed stays in place.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !fire |=> in_valid_reg && $stable(in_byte_reg))
    else $error("pending byte lost");

    // An ending byte is never processed while an unread result is held.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire && result.done |-> out_free)
    else $error("result register overwritten");

endmodule

`default_nettype wire
